// ===== rtl/postfix_stack_evaluator_macros.svh =====
// Assertion macros for the postfix stack evaluator.
`ifndef POSTFIX_STACK_EVALUATOR_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while rst_n is low
`define PSE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off while rst_n is low
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PSE_ASSERT(lbl, ante, cons, msg)
`define PSE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/psev_pkg.sv =====
// Shared types and constants of the postfix stack evaluator.
package psev_pkg;

  localparam int DATA_W          = 32;
  localparam int MODE_W          = 3;
  localparam int STATUS_W        = 2;
  localparam int STACK_DEPTH_DEF = 64;

  // Token queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_MUL  = 3'd3,
    MODE_END  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_BAD_DEPTH = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // One classified token as it sits in the queue
  typedef struct packed {
    mode_t                    mode;
    logic signed [DATA_W-1:0] operand;
  } token_t;

endpackage

// ===== rtl/psev_front.sv =====
// Token intake: accepts input transactions, drops meaningless modes, queues tokens.
module psev_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [psev_pkg::MODE_W-1:0]           in_mode,
  input  logic signed [psev_pkg::DATA_W-1:0]    in_operand,
  output logic                                  q_valid,
  output psev_pkg::token_t                      q_token,
  input  logic                                  q_pop
);

  psev_pkg::token_t                   fifo_r [psev_pkg::QUEUE_DEPTH];
  logic [psev_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [psev_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [psev_pkg::QCNT_W-1:0]        count_r, count_nxt;
  logic                               keep;
  logic                               push;
  logic                               pop;

  // Classify: only modes push through end are carried out
  always_comb begin
    unique case (in_mode)
      psev_pkg::MODE_PUSH, psev_pkg::MODE_ADD, psev_pkg::MODE_SUB,
      psev_pkg::MODE_MUL, psev_pkg::MODE_END: keep = 1'b1;
      default:                                 keep = 1'b0;
    endcase
  end

  assign in_stall = (count_r == psev_pkg::QCNT_W'(psev_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count_r != '0);
  assign q_token  = fifo_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r].mode    <= psev_pkg::mode_t'(in_mode);
      fifo_r[wr_ptr_r].operand <= in_operand;
    end
  end

endmodule

// ===== rtl/psev_back.sv =====
// Token execution: value stack with two top entries in registers, result register.
`include "postfix_stack_evaluator_macros.svh"

module psev_back #(
  parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_valid,
  input  psev_pkg::token_t                      q_token,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [psev_pkg::DATA_W-1:0]    out_value,
  output logic [psev_pkg::STATUS_W-1:0]         out_status
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int EW = DW + 1;
  localparam int AW = $clog2(STACK_DEPTH);

  // Stack: tos/nos registers, third entry prefetched from memory
  logic [psev_pkg::DATA_W-1:0] mem [STACK_DEPTH];
  logic [psev_pkg::DATA_W-1:0] tos_r, tos_nxt;
  logic [psev_pkg::DATA_W-1:0] nos_r, nos_nxt;
  logic [psev_pkg::DATA_W-1:0] third_r;
  logic [DW-1:0]               depth_r, depth_nxt;
  logic                        failed_r, failed_nxt;
  logic [EW-1:0]               depth_e;
  logic [AW-1:0]               wr_addr;
  logic [AW-1:0]               rd_addr;
  logic                        mem_we, mem_re, third_fwd;
  logic [psev_pkg::DATA_W-1:0] alu_res;

  logic                        emit;
  logic [psev_pkg::DATA_W-1:0] res_value;
  psev_pkg::status_t           res_status;
  logic                        out_free;
  logic                        res_load;

  logic                        out_valid_r;
  logic [psev_pkg::DATA_W-1:0] out_value_r;
  psev_pkg::status_t           out_status_r;

  assign depth_e = {1'b0, depth_r};
  assign wr_addr = AW'(depth_e - EW'(2));
  assign rd_addr = AW'(depth_e - EW'(4));

  // Arithmetic on bottom (nos) and top (tos); low 32 bits wrap
  always_comb begin
    unique case (q_token.mode)
      psev_pkg::MODE_ADD: alu_res = nos_r + tos_r;
      psev_pkg::MODE_SUB: alu_res = nos_r - tos_r;
      default:            alu_res = nos_r * tos_r;
    endcase
  end

  // Effect of the token at the head of the queue
  always_comb begin
    emit       = 1'b0;
    res_value  = '0;
    res_status = psev_pkg::ST_OK;
    depth_nxt  = depth_r;
    failed_nxt = failed_r;
    tos_nxt    = tos_r;
    nos_nxt    = nos_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    third_fwd  = 1'b0;
    if (q_token.mode == psev_pkg::MODE_END) begin
      emit       = !failed_r;
      depth_nxt  = '0;
      failed_nxt = 1'b0;
      if (depth_r == DW'(1)) begin
        res_value = tos_r;
      end else begin
        res_status = psev_pkg::ST_BAD_DEPTH;
      end
    end else if (!failed_r) begin
      if (q_token.mode == psev_pkg::MODE_PUSH) begin
        if (depth_r == DW'(STACK_DEPTH)) begin
          emit       = 1'b1;
          res_status = psev_pkg::ST_OVERFLOW;
          failed_nxt = 1'b1;
        end else begin
          // nos spills to memory and becomes the third entry
          mem_we    = (depth_r >= DW'(2));
          third_fwd = 1'b1;
          nos_nxt   = tos_r;
          tos_nxt   = q_token.operand;
          depth_nxt = depth_r + 1'b1;
        end
      end else if (depth_r < DW'(2)) begin
        emit       = 1'b1;
        res_status = psev_pkg::ST_UNDERFLOW;
        failed_nxt = 1'b1;
      end else begin
        // operator: third entry moves up, refill third from memory
        tos_nxt   = alu_res;
        nos_nxt   = third_r;
        mem_re    = (depth_r > DW'(3));
        depth_nxt = depth_r - 1'b1;
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_valid && (!emit || out_free);
  assign res_load = q_pop && emit;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        depth_r  <= depth_nxt;
        failed_r <= failed_nxt;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Top-of-stack and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      tos_r <= tos_nxt;
      nos_r <= nos_nxt;
    end
    if (res_load) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  // Stack memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (q_pop && mem_we) begin
      mem[wr_addr] <= nos_r;
    end
    if (q_pop && third_fwd) begin
      third_r <= nos_r;
    end else if (q_pop && mem_re) begin
      third_r <= mem[rd_addr];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  `PSE_ASSERT(a_depth_bound, 1'b1, depth_r <= DW'(STACK_DEPTH), "stack depth beyond bound")
  `PSE_ASSERT(a_no_overwrite, out_valid_r && out_stall, !res_load, "pending result overwritten")
  `PSE_ASSERT_NEXT(a_third_fwd, q_pop && third_fwd && !failed_r && depth_r >= DW'(2), third_r == $past(nos_r), "third entry not forwarded on push")
  `PSE_ASSERT_NEXT(a_error_latch, res_load && (res_status == psev_pkg::ST_UNDERFLOW || res_status == psev_pkg::ST_OVERFLOW), failed_r, "error not latched")

endmodule

// ===== rtl/postfix_stack_evaluator.sv =====
// Top level of the postfix stack evaluator.
// Evaluates postfix expressions one token per input transaction and sustains one
// token per clock cycle unless out_stall holds back a result. With the queue empty
// and the result register free, the end token (or faulting token) is written into
// the queue at the accepting edge, executed from the queue head in the next cycle,
// and its result loaded into the result register that drives out_valid. The top
// two stack entries sit in registers and the third is kept prefetched from a
// single-port stack memory, so an operator never waits on a memory read; a 32x32
// multiplier keeping the low word sets the critical path. A four-entry token queue
// decouples intake from execution; in_stall rises only when that queue is full,
// which happens only while out_stall holds back a result.
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = psev_pkg::STACK_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [psev_pkg::MODE_W-1:0]           in_mode,
  input  logic signed [psev_pkg::DATA_W-1:0]    in_operand,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [psev_pkg::DATA_W-1:0]    out_value,
  output logic [psev_pkg::STATUS_W-1:0]         out_status
);

  logic             q_valid;
  logic             q_pop;
  psev_pkg::token_t q_token;

  // Intake and token queue
  psev_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_operand (in_operand),
    .q_valid    (q_valid),
    .q_token    (q_token),
    .q_pop      (q_pop)
  );

  // Stack execution and result register
  psev_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_token    (q_token),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule
